>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the block buffer cache; compiled away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Combinational property checked at every edge outside reset
`define HB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hbbc assertion failed");
// Implication property checked at every edge outside reset
`define HB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbbc implication failed");
// Next-cycle implication
`define HB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbbc next-cycle check failed");
`else
`define HB_ASSERT(lbl, expr)
`define HB_ASSERT_IMP(lbl, ante, cons)
`define HB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/hbbc_pkg.sv
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared types and codes of the hashed block buffer cache.
// ----------------------------------------------------------------------------
`default_nettype none
package hbbc_pkg;

  // Request codes
  localparam logic [1:0] REQ_GET     = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_PIN     = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NOFREE = 2'd1;
  localparam logic [1:0] STATUS_COUNT  = 2'd2;

  localparam logic [15:0] COUNT_MAX  = 16'hffff;
  localparam logic [31:0] STAMP_NONE = 32'hffffffff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  slot_set;
    logic [4:0]  slot_way;
    logic [31:0] time_now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  result_set;
    logic [4:0]  result_way;
    logic        was_hit;
    logic        needs_disk_read;
    logic [15:0] count_after;
  } rsp_t;

  // One buffer slot
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [15:0] cnt;
    logic [31:0] stamp;
    logic        vld;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODW,
    ST_RD,
    ST_LOOK,
    ST_SCAN,
    ST_VIC,
    ST_WR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/hbbc_set_mod.sv
// ----------------------------------------------------------------------------
// hbbc_set_mod
// Block number modulo the set count, folded in one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hbbc_set_mod
  import hbbc_pkg::*;
#(
  parameter int NUM_SETS = 17,
  localparam int SET_W = $clog2(NUM_SETS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       value,
  output logic                   done,
  output logic [SET_W-1:0]       result
);

  localparam logic [SET_W:0] NMOD = (SET_W + 1)'(NUM_SETS);

  logic [31:0]      shreg;
  logic [1:0]       cnt;
  logic             run;
  logic [SET_W-1:0] acc;
  logic [SET_W-1:0] acc_next;

  // Fold in the next byte, MSB first: one compare-subtract per bit
  always_comb begin
    logic [SET_W:0] t;
    acc_next = acc;
    for (int b = 7; b >= 0; b--) begin
      t = {acc_next, shreg[24 + b]};
      if (t >= NMOD) t = t - NMOD;
      acc_next = t[SET_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      acc   <= '0;
    end else if (run) begin
      shreg <= shreg << 8;
      acc   <= acc_next;
    end
  end

  assign result = acc;

endmodule
`default_nettype wire

>>> sv/hashed_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit
// Set-associative tag store for disk block buffers with LRU and ref counts.
// ----------------------------------------------------------------------------
// One request at a time. A get first forms the set index (block number
// mod NUM_SETS, a byte per cycle, then a done pulse), reads the set's row
// from the tag memory and does the tag compare. A hit then passes through
// a write-back and a result state before its response is valid. A miss
// scans the ways one per cycle for the LRU victim and installs it before
// write-back; when no slot is free the write-back is skipped. Release and
// pin read, update and write back the addressed slot; out-of-range slots
// and unknown requests go straight to the result state. The next request
// is taken in the idle state that follows the loading of the response,
// and a stalled response holds the block until it drains. Each row
// carries a valid flag cleared at reset, so the memory needs no clearing
// pass after reset.
`default_nettype none
`include "assert_macros.svh"
module hashed_block_buffer_cache_unit
  import hbbc_pkg::*;
#(
  parameter int NUM_SETS = 17,
  parameter int NUM_WAYS = 20
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_req,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_rsp
);

  localparam int WIDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SIDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SET_W  = $clog2(NUM_SETS + 1);

  typedef entry_t [NUM_WAYS-1:0] row_t;

  state_t            state;
  state_t            state_next;
  req_t              req;
  logic [SIDX_W-1:0] set_idx;
  row_t              mem [NUM_SETS];
  row_t              rdata;
  logic              rvalid;
  logic [NUM_SETS-1:0] row_valid;
  row_t              row;
  row_t              wrow;
  rsp_t              rsp;
  rsp_t              bad_rsp;
  logic [WIDX_W-1:0] scan_way;
  logic [WIDX_W-1:0] pick;
  logic [31:0]       least;
  logic              found;
  logic              mod_start;
  logic              mod_done;
  logic [SET_W-1:0]  mod_result;
  logic              accept;
  logic              is_get;
  logic              slot_bad;
  logic              hit;
  logic [WIDX_W-1:0] hit_way;
  row_t              lk_row;
  rsp_t              lk_rsp;
  row_t              vic_row;
  rsp_t              vic_rsp;
  entry_t            cur;
  logic              take;

  // Set index unit
  hbbc_set_mod #(.NUM_SETS(NUM_SETS)) u_set_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (in_req.block_number),
    .done   (mod_done),
    .result (mod_result)
  );

  assign accept    = in_valid && !in_stall;
  assign is_get    = (in_req.req_type == REQ_GET);
  assign mod_start = accept && is_get;
  assign slot_bad  = ({2'b00, in_req.slot_set} >= 7'(NUM_SETS)) ||
                     ({1'b0, in_req.slot_way} >= 6'(NUM_WAYS));

  // Response for a slot out of range
  always_comb begin
    bad_rsp            = '0;
    bad_rsp.status     = STATUS_COUNT;
    bad_rsp.result_set = in_req.slot_set;
    bad_rsp.result_way = in_req.slot_way;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (is_get) state_next = ST_MODW;
          else if ((in_req.req_type == REQ_RELEASE || in_req.req_type == REQ_PIN)
                   && !slot_bad) state_next = ST_RD;
          else state_next = ST_DONE;
        end
      end
      ST_MODW: if (mod_done) state_next = ST_RD;
      ST_RD:   state_next = ST_LOOK;
      ST_LOOK: begin
        if (req.req_type == REQ_GET && !hit) state_next = ST_SCAN;
        else state_next = ST_WR;
      end
      ST_SCAN: if (scan_way == WIDX_W'(NUM_WAYS - 1)) state_next = ST_VIC;
      ST_VIC:  state_next = found ? ST_WR : ST_DONE;
      ST_WR:   state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Tag memory, one row per set
  always_ff @(posedge clk) begin
    if (state == ST_WR) mem[set_idx] <= wrow;
    rdata <= mem[set_idx];
  end

  // Row valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      rvalid <= row_valid[set_idx];
      if (state == ST_WR) row_valid[set_idx] <= 1'b1;
    end
  end

  assign row = rvalid ? rdata : '0;

  // Tag compare, lowest way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w].dev == req.device_id && row[w].blk == req.block_number) begin
        hit     = 1'b1;
        hit_way = WIDX_W'(w);
      end
    end
  end

  // Hit update or slot release/pin
  always_comb begin
    logic [WIDX_W-1:0] w;
    entry_t e;
    lk_row = row;
    lk_rsp = '0;
    if (req.req_type == REQ_GET) begin
      w = hit_way;
      e = row[w];
      lk_rsp.was_hit         = 1'b1;
      lk_rsp.needs_disk_read = !e.vld;
      if (e.cnt == COUNT_MAX) lk_rsp.status = STATUS_COUNT;
      else e.cnt = e.cnt + 16'd1;
      e.stamp = req.time_now;
      e.vld   = 1'b1;
    end else begin
      w = WIDX_W'(req.slot_way);
      e = row[w];
      if (req.req_type == REQ_RELEASE) begin
        if (e.cnt == '0) lk_rsp.status = STATUS_COUNT;
        else e.cnt = e.cnt - 16'd1;
      end else begin
        if (e.cnt == COUNT_MAX) lk_rsp.status = STATUS_COUNT;
        else e.cnt = e.cnt + 16'd1;
      end
    end
    lk_row[w]          = e;
    lk_rsp.result_set  = 5'(set_idx);
    lk_rsp.result_way  = 5'(w);
    lk_rsp.count_after = e.cnt;
  end

  // Victim scan step
  assign cur  = row[scan_way];
  assign take = (cur.cnt == '0) && (cur.stamp < least);

  // Victim install
  always_comb begin
    vic_row = row;
    vic_rsp = '0;
    vic_rsp.result_set = 5'(set_idx);
    if (found) begin
      vic_row[pick].dev   = req.device_id;
      vic_row[pick].blk   = req.block_number;
      vic_row[pick].stamp = req.time_now;
      vic_row[pick].cnt   = 16'd1;
      vic_row[pick].vld   = 1'b1;
      vic_rsp.result_way      = 5'(pick);
      vic_rsp.needs_disk_read = 1'b1;
      vic_rsp.count_after     = 16'd1;
    end else begin
      vic_rsp.status = STATUS_NOFREE;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req     <= in_req;
          set_idx <= SIDX_W'(in_req.slot_set);
          rsp     <= ((in_req.req_type == REQ_RELEASE || in_req.req_type == REQ_PIN)
                      && slot_bad) ? bad_rsp : '0;
        end
      end
      ST_MODW: if (mod_done) set_idx <= SIDX_W'(mod_result);
      ST_LOOK: begin
        wrow     <= lk_row;
        rsp      <= lk_rsp;
        scan_way <= '0;
        pick     <= '0;
        least    <= STAMP_NONE;
        found    <= 1'b0;
      end
      ST_SCAN: begin
        if (take) begin
          least <= cur.stamp;
          pick  <= scan_way;
          found <= 1'b1;
        end
        scan_way <= scan_way + 1'b1;
      end
      ST_VIC: begin
        wrow <= vic_row;
        rsp  <= vic_rsp;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) out_rsp <= rsp;
  end

  // Checks
  `HB_ASSERT_NXT(a_accept_leaves_idle, accept, state != ST_IDLE)
  `HB_ASSERT_NXT(a_write_then_done, state == ST_WR, state == ST_DONE)
  `HB_ASSERT_IMP(a_rise_from_done, $rose(out_valid), $past(state) == ST_DONE)
  `HB_ASSERT_IMP(a_hit_never_nofree, out_valid && out_rsp.was_hit, out_rsp.status != STATUS_NOFREE)
  `HB_ASSERT_IMP(a_scan_in_range, state == ST_SCAN, int'(scan_way) < NUM_WAYS)

endmodule
`default_nettype wire

>>> sim/hashed_block_buffer_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit_tb
// Drives get, release and pin requests into the buffer cache, predicts every
// response with a behavioral copy of the tag store and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module hashed_block_buffer_cache_unit_tb
  import hbbc_pkg::*;
;

  localparam int SETS  = 17;
  localparam int WAYS  = 20;
  localparam int SLOTS = SETS * WAYS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REQ_BAD = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;

  hashed_block_buffer_cache_unit #(.NUM_SETS(SETS), .NUM_WAYS(WAYS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  // Predicted copy of the tag store
  logic [7:0]  mdl_dev   [SLOTS];
  logic [31:0] mdl_blk   [SLOTS];
  logic [15:0] mdl_cnt   [SLOTS];
  logic [31:0] mdl_stamp [SLOTS];
  logic        mdl_vld   [SLOTS];

  rsp_t pending_rsp[$];
  int   errors;
  int   n_sent;
  int   n_recv;
  int   n_hit;
  int   n_nofree;
  int   n_sat;
  bit   quiet;       // no idling in the last part
  bit   hold_off;    // long receiver stall
  bit   stim_done;   // every request has been sent
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the response to one request and update the copy
  function automatic rsp_t cache_respond(req_t r);
    rsp_t o;
    int base, idx, pick;
    logic [31:0] least;
    logic [4:0] set_of;
    bit found;
    o = '0;
    if (r.req_type == REQ_GET) begin
      set_of = 5'(r.block_number % SETS);
      base = set_of * WAYS;
      o.result_set = set_of;
      for (int w = 0; w < WAYS; w++) begin
        idx = base + w;
        if (mdl_dev[idx] == r.device_id && mdl_blk[idx] == r.block_number) begin
          o.was_hit = 1'b1;
          o.result_way = 5'(w);
          o.needs_disk_read = ~mdl_vld[idx];
          if (mdl_cnt[idx] == COUNT_MAX) o.status = STATUS_COUNT;
          else mdl_cnt[idx] = mdl_cnt[idx] + 16'd1;
          mdl_stamp[idx] = r.time_now;
          mdl_vld[idx] = 1'b1;
          o.count_after = mdl_cnt[idx];
          return o;
        end
      end
      least = STAMP_NONE;
      found = 1'b0;
      pick = 0;
      for (int w = 0; w < WAYS; w++) begin
        idx = base + w;
        if (mdl_cnt[idx] == 16'd0 && mdl_stamp[idx] < least) begin
          least = mdl_stamp[idx];
          pick = w;
          found = 1'b1;
        end
      end
      if (!found) begin
        o.status = STATUS_NOFREE;
        return o;
      end
      idx = base + pick;
      mdl_dev[idx] = r.device_id;
      mdl_blk[idx] = r.block_number;
      mdl_stamp[idx] = r.time_now;
      mdl_cnt[idx] = 16'd1;
      mdl_vld[idx] = 1'b1;
      o.result_way = 5'(pick);
      o.needs_disk_read = 1'b1;
      o.count_after = 16'd1;
    end else if (r.req_type == REQ_RELEASE || r.req_type == REQ_PIN) begin
      o.result_set = r.slot_set;
      o.result_way = r.slot_way;
      if (r.slot_set >= SETS || r.slot_way >= WAYS) begin
        o.status = STATUS_COUNT;
        return o;
      end
      idx = r.slot_set * WAYS + r.slot_way;
      if (r.req_type == REQ_RELEASE) begin
        if (mdl_cnt[idx] == 16'd0) o.status = STATUS_COUNT;
        else mdl_cnt[idx] = mdl_cnt[idx] - 16'd1;
      end else begin
        if (mdl_cnt[idx] == COUNT_MAX) o.status = STATUS_COUNT;
        else mdl_cnt[idx] = mdl_cnt[idx] + 16'd1;
      end
      o.count_after = mdl_cnt[idx];
    end
    return o;
  endfunction

  // Directed table: request plus a typed-in response where obvious
  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } row_t;
  row_t script[$];

  function automatic req_t mk(logic [1:0] t, logic [7:0] d, logic [31:0] b,
                              logic [4:0] s, logic [4:0] w, logic [31:0] tm);
    req_t r;
    r.req_type = t; r.device_id = d; r.block_number = b;
    r.slot_set = s; r.slot_way = w; r.time_now = tm;
    return r;
  endfunction

  function automatic rsp_t rs(logic [1:0] st, logic [4:0] s, logic [4:0] w,
                              logic h, logic rd, logic [15:0] c);
    rsp_t o;
    o.status = st; o.result_set = s; o.result_way = w;
    o.was_hit = h; o.needs_disk_read = rd; o.count_after = c;
    return o;
  endfunction

  task automatic add_row(req_t r, bit typed, rsp_t e);
    row_t x;
    x.r = r; x.typed = typed; x.e = e;
    script.push_back(x);
  endtask

  // Send one request; hold it until accepted
  task automatic send_req(req_t r, bit typed, rsp_t e);
    rsp_t p;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    p = cache_respond(r);
    if (typed && p !== e) begin
      errors++;
      $error("directed row mismatch: table %h, predictor %h", e, p);
    end
    pending_rsp.push_back(typed ? e : p);
    n_sent++;
  endtask

  function automatic req_t rand_req();
    req_t r;
    int k;
    r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom}));
    k = $urandom_range(0, 99);
    // Small device/block pool so hits and set fill-ups happen often
    if ($urandom_range(0, 9) != 0) begin
      r.device_id = 8'($urandom_range(0, 3));
      r.block_number = 32'($urandom_range(0, 60));
      if ($urandom_range(0, 3) == 0) r.block_number = r.block_number + 32'hffff_ff00;
    end
    r.time_now = (k % 3 == 0) ? $urandom : 32'($urandom_range(0, 2000));
    if ($urandom_range(0, 40) == 0) r.time_now = STAMP_NONE;
    if (k < 55) r.req_type = REQ_GET;
    else if (k < 78) r.req_type = REQ_RELEASE;
    else if (k < 97) r.req_type = REQ_PIN;
    else r.req_type = REQ_BAD;
    if ($urandom_range(0, 15) != 0) begin
      r.slot_set = 5'($urandom_range(0, SETS - 1));
      r.slot_way = 5'($urandom_range(0, WAYS - 1));
    end
    return r;
  endfunction

  // Stimulus
  initial begin
    rsp_t z;
    req_t r;
    z = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    quiet = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    n_sent = 0;
    for (int i = 0; i < SLOTS; i++) begin
      mdl_dev[i] = '0; mdl_blk[i] = '0; mdl_cnt[i] = '0;
      mdl_stamp[i] = '0; mdl_vld[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero tag hits the untouched way 0 of set 0 and asks for a read
    add_row(mk(REQ_GET, 8'd0, 32'd0, 5'd0, 5'd0, 32'd5), 1, rs(STATUS_OK, 0, 0, 1, 1, 1));
    add_row(mk(REQ_GET, 8'd0, 32'd0, 5'd0, 5'd0, 32'd6), 1, rs(STATUS_OK, 0, 0, 1, 0, 2));
    // Miss: lowest unreferenced way with stamp 0
    add_row(mk(REQ_GET, 8'hff, 32'hffffffff, 5'd31, 5'd31, 32'hffffffff), 0, z);
    add_row(mk(REQ_GET, 8'h12, 32'd17, 5'd0, 5'd0, 32'd0), 1, rs(STATUS_OK, 0, 2, 0, 1, 1));
    add_row(mk(REQ_RELEASE, 8'h0, 32'd0, 5'd0, 5'd1, 32'd0), 1, rs(STATUS_OK, 0, 1, 0, 0, 0));
    add_row(mk(REQ_RELEASE, 8'h0, 32'd0, 5'd0, 5'd1, 32'd0), 1, rs(STATUS_COUNT, 0, 1, 0, 0, 0));
    add_row(mk(REQ_PIN, 8'h0, 32'd0, 5'd16, 5'd19, 32'd0), 1, rs(STATUS_OK, 16, 19, 0, 0, 1));
    // Out-of-range slots
    add_row(mk(REQ_PIN, 8'h0, 32'd0, 5'd17, 5'd0, 32'd0), 1, rs(STATUS_COUNT, 17, 0, 0, 0, 0));
    add_row(mk(REQ_RELEASE, 8'h0, 32'd0, 5'd0, 5'd20, 32'd0), 1, rs(STATUS_COUNT, 0, 20, 0, 0, 0));
    add_row(mk(REQ_RELEASE, 8'h0, 32'd0, 5'd31, 5'd31, 32'd0), 1, rs(STATUS_COUNT, 31, 31, 0, 0, 0));
    // Unknown request
    add_row(mk(REQ_BAD, 8'hff, 32'hffffffff, 5'd31, 5'd31, 32'hffffffff), 1, z);
    // Queue eight referenced gets to set 3; the full fill follows below
    for (int w = 0; w < WAYS; w++)
      add_row(mk(REQ_GET, 8'h40, 32'd3 + 32'd17 * 32'(w + 1), 0, 0, 32'd100 + w), 0, z);
    script = script[0:10];
    for (int w = 0; w < 8; w++)
      add_row(mk(REQ_GET, 8'h40, 32'd3 + 32'd17 * 32'(w + 1), 0, 0, 32'd100 + w), 0, z);
    foreach (script[i]) send_req(script[i].r, script[i].typed, script[i].e);

    // Fill set 3 completely so that a miss finds no free slot
    for (int w = 0; w < WAYS; w++)
      send_req(mk(REQ_GET, 8'h41, 32'd3 + 32'd17 * 32'(w + 1), 0, 0, 32'd200 + w), 0, z);
    send_req(mk(REQ_GET, 8'h42, 32'd3, 0, 0, 32'd300), 1, rs(STATUS_NOFREE, 3, 0, 0, 0, 0));
    // Drain set 3 for later random traffic
    for (int w = 0; w < WAYS; w++) begin
      send_req(mk(REQ_RELEASE, 0, 0, 5'd3, 5'(w), 0), 0, z);
      send_req(mk(REQ_RELEASE, 0, 0, 5'd3, 5'(w), 0), 0, z);
    end

    // Random traffic; a long receiver hold-off early on
    for (int i = 0; i < 870; i++) begin
      if (i == 100) hold_off = 1'b1;
      if (i == 800) quiet = 1'b1;
      r = rand_req();
      send_req(r, 0, z);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall bursts plus one long hold-off
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Response checker and watchdog
  initial begin
    rsp_t e;
    errors = 0; n_recv = 0; n_hit = 0; n_nofree = 0; n_sat = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst) continue;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        n_recv++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $error("response with none expected: %h", out_rsp);
        end else begin
          e = pending_rsp.pop_front();
          if (out_rsp.was_hit) n_hit++;
          if (out_rsp.status == STATUS_NOFREE) n_nofree++;
          if (out_rsp.status == STATUS_COUNT) n_sat++;
          if (out_rsp.status !== e.status) begin
            errors++; $error("status: expected %0d got %0d", e.status, out_rsp.status);
          end
          if (out_rsp.result_set !== e.result_set) begin
            errors++;
            $error("result_set: expected %0d got %0d", e.result_set, out_rsp.result_set);
          end
          if (out_rsp.result_way !== e.result_way) begin
            errors++;
            $error("result_way: expected %0d got %0d", e.result_way, out_rsp.result_way);
          end
          if (out_rsp.was_hit !== e.was_hit) begin
            errors++; $error("was_hit: expected %0d got %0d", e.was_hit, out_rsp.was_hit);
          end
          if (out_rsp.needs_disk_read !== e.needs_disk_read) begin
            errors++;
            $error("needs_disk_read: expected %0d got %0d",
                   e.needs_disk_read, out_rsp.needs_disk_read);
          end
          if (out_rsp.count_after !== e.count_after) begin
            errors++;
            $error("count_after: expected %0d got %0d", e.count_after, out_rsp.count_after);
          end
        end
      end
      if (stim_done && pending_rsp.size() == 0 && idle_cycles >= 50) begin
        $display("Sent %0d requests, checked %0d responses", n_sent, n_recv);
        $display("hits %0d, no-free %0d, count errors %0d", n_hit, n_nofree, n_sat);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d responses outstanding", pending_rsp.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/hbbc_pkg.sv
sv/hbbc_set_mod.sv
sv/hashed_block_buffer_cache_unit.sv
sim/hashed_block_buffer_cache_unit_tb.sv
